// ===== hw/rtl/cre_pkg.sv =====
// Shared types, constants and helper functions of the cylinder ray emitter.
// No dependencies; compiled before every other file of the block.
package cre_pkg;

	localparam int NSTAGE = 48;
	localparam logic [16:0] PHASE_PER_CODE = 17'd65503;
	localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;
	localparam logic [15:0] RADIUS_RST = 16'd256;
	localparam logic [15:0] LENGTH_RST = 16'd256;
	localparam logic [2:0] REG_RADIUS = 3'd0;
	localparam logic [2:0] REG_LENGTH = 3'd4;

	typedef struct packed {
		logic signed [15:0] axial_sample;
		logic [15:0] angle_sample;
		logic signed [15:0] raw_dir_x;
		logic signed [15:0] raw_dir_y;
		logic signed [15:0] raw_dir_z;
	} sample_t;

	typedef struct packed {
		logic signed [15:0] normal_y;
		logic signed [15:0] normal_z;
		logic signed [23:0] pos_x;
		logic signed [23:0] pos_y;
		logic signed [23:0] pos_z;
		logic signed [15:0] dir_x;
		logic signed [15:0] dir_y;
		logic signed [15:0] dir_z;
		logic degenerate;
	} ray_t;

	// Arctangent of 2^-i in phase units, a full turn being 2^32.
	function automatic logic signed [33:0] atan_turn(input logic [3:0] i);
		logic signed [33:0] r;
		case (i)
			4'd0: r = 34'sd536870912;
			4'd1: r = 34'sd316933406;
			4'd2: r = 34'sd167458907;
			4'd3: r = 34'sd85004756;
			4'd4: r = 34'sd42667332;
			4'd5: r = 34'sd21354465;
			4'd6: r = 34'sd10679838;
			4'd7: r = 34'sd5340245;
			4'd8: r = 34'sd2670167;
			4'd9: r = 34'sd1335087;
			4'd10: r = 34'sd667544;
			4'd11: r = 34'sd333772;
			4'd12: r = 34'sd166886;
			4'd13: r = 34'sd83443;
			4'd14: r = 34'sd41722;
			default: r = 34'sd20861;
		endcase
		return r;
	endfunction

	// Clamp a signed value to the Q1.15 range.
	function automatic logic signed [15:0] sat16(input logic signed [33:0] v);
		logic signed [15:0] r;
		if (v > 34'sd32767) r = 16'sh7fff;
		else if (v < -34'sd32768) r = 16'sh8000;
		else r = v[15:0];
		return r;
	endfunction

endpackage

// ===== hw/rtl/cre_in_if.sv =====
// Sample channel of the cylinder ray emitter: valid, ready and one sample set.
// Depends on cre_pkg.
interface cre_in_if import cre_pkg::*; ();
	logic valid;
	logic ready;
	sample_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ===== hw/rtl/cre_out_if.sv =====
// Ray channel of the cylinder ray emitter: valid, ready and one ray.
// Depends on cre_pkg.
interface cre_out_if import cre_pkg::*; ();
	logic valid;
	logic ready;
	ray_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ===== hw/rtl/cylinder_ray_emitter_top.sv =====
// Cylinder ray emitter: turns one set of uniform samples into one surface ray.
// Depends on cre_pkg, cre_in_if and cre_out_if.
//
// Usage: the sample channel takes one transaction (axial sample, angle code
// and three raw direction components) whenever valid and ready are both high.
// For each of them the ray channel delivers exactly one transaction with the
// surface normal, the ray origin, the outward unit direction and a degenerate
// flag, in order. The block accepts one transaction per cycle while the
// ray channel takes rays or a stage is empty. Each ray passes through a
// 16-step CORDIC alongside a 26-step square root, then three 16-step
// dividers side by side, each step one register stage. Every stage has its own valid bit
// and moves on when the next stage is free, so bubbles close up and a
// stalled ray channel stops only the full stages with no empty stage after
// them; the sample channel stays ready as long as any stage can still move.
// Radius and length are written over the APB port at byte addresses 0 and 4,
// only while the block is idle: a rule for the user, not enforced by the block.
// Reset empties the pipeline and sets both registers to 1.0.
module cylinder_ray_emitter_top import cre_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [2:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	cre_in_if.sink sample,
	cre_out_if.source ray
);

	// Everything an item carries through the stages. Each field is filled by
	// the stage that computes it and then rides along unchanged.
	typedef struct packed {
		logic signed [15:0] rx;
		logic signed [15:0] ry;
		logic signed [15:0] rz;
		logic [31:0] phase;
		logic [31:0] sqx;
		logic [31:0] sqy;
		logic [31:0] sqz;
		logic signed [32:0] pxprod;
		logic signed [32:0] pyprod;
		logic signed [32:0] pzprod;
		logic signed [23:0] px;
		logic signed [23:0] py;
		logic signed [23:0] pz;
		logic signed [33:0] cx;
		logic signed [33:0] cy;
		logic signed [33:0] cz;
		logic [1:0] quad;
		logic signed [15:0] ny;
		logic signed [15:0] nz;
		logic [52:0] sq_val;
		logic [52:0] sq_res;
		logic deg;
		logic [25:0] mval;
		logic [2:0] neg;
		logic [2:0][41:0] rem;
		logic [2:0][15:0] dq;
		logic [2:0][15:0] dir;
		logic [2:0][39:0] prod;
	} pipe_t;

	localparam int ST_IN = 1;
	localparam int ST_INIT = 2;
	localparam int ST_ITER0 = 3;
	localparam int CORDIC_LAST = 18;
	localparam int ST_CSROUND = 19;
	localparam int ST_PMUL = 20;
	localparam int ST_PROUND = 21;
	localparam int SQRT_LAST = 28;
	localparam int ST_DIVINIT = 29;
	localparam int DIV_LAST = 45;
	localparam int ST_DIR = 46;
	localparam int ST_DOT = 47;

	logic [15:0] radius_q;
	logic [15:0] length_q;
	logic [NSTAGE:1] v_s;
	pipe_t pl_s [1:NSTAGE];
	logic [NSTAGE:1] en_w;

	// Configuration registers.
	assign pready = 1'b1;
	assign prdata = paddr[2] ? {16'd0, length_q} : {16'd0, radius_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RADIUS_RST;
			length_q <= LENGTH_RST;
		end else if (psel && penable && pwrite) begin
			unique case ({paddr[2], 2'b00})
				REG_RADIUS: radius_q <= pwdata[15:0];
				REG_LENGTH: length_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// A stage may load when it is empty or when the stage after it moves.
	always_comb begin
		en_w[NSTAGE] = !v_s[NSTAGE] || ray.ready;
		for (int k = NSTAGE - 1; k >= 1; k--) begin
			en_w[k] = !v_s[k] || en_w[k + 1];
		end
	end

	assign sample.ready = en_w[1];

	for (genvar k = 1; k <= NSTAGE; k++) begin : g_stage
		localparam int CI = (k >= ST_ITER0 && k <= CORDIC_LAST) ? k - ST_ITER0 : 0;
		localparam int SB = (k >= ST_ITER0 && k <= SQRT_LAST) ? 50 - 2 * (k - ST_ITER0) : 0;
		localparam int DJ = (k > ST_DIVINIT && k <= DIV_LAST) ? DIV_LAST - k : 0;

		pipe_t prev_w;
		pipe_t nx_w;
		logic vin_w;

		if (k == ST_IN) begin : g_first
			assign prev_w = '0;
			assign vin_w = sample.valid;
		end else begin : g_next
			assign prev_w = pl_s[k - 1];
			assign vin_w = v_s[k - 1];
		end

		always_comb begin
			logic signed [33:0] sh_x;
			logic signed [33:0] sh_y;
			logic signed [33:0] rnd;
			logic signed [33:0] c_w;
			logic signed [33:0] s_w;
			logic [33:0] ss;
			logic [52:0] trial;
			logic signed [16:0] rv;
			logic [15:0] mag;
			logic [42:0] dvs;
			logic signed [41:0] dot;
			logic [15:0] q;

			nx_w = prev_w;
			sh_x = '0;
			sh_y = '0;
			rnd = '0;
			c_w = '0;
			s_w = '0;
			ss = '0;
			trial = '0;
			rv = '0;
			mag = '0;
			dvs = '0;
			dot = '0;
			q = '0;

			if (k == ST_IN) begin
				nx_w.rx = sample.data.raw_dir_x;
				nx_w.ry = sample.data.raw_dir_y;
				nx_w.rz = sample.data.raw_dir_z;
				nx_w.phase = 32'({1'b0, sample.data.angle_sample} * PHASE_PER_CODE);
				nx_w.sqx = 32'(sample.data.raw_dir_x * sample.data.raw_dir_x);
				nx_w.sqy = 32'(sample.data.raw_dir_y * sample.data.raw_dir_y);
				nx_w.sqz = 32'(sample.data.raw_dir_z * sample.data.raw_dir_z);
				nx_w.pxprod = $signed({1'b0, length_q}) * sample.data.axial_sample;
			end

			if (k == ST_INIT) begin
				ss = {2'b00, prev_w.sqx} + {2'b00, prev_w.sqy} + {2'b00, prev_w.sqz};
				nx_w.deg = (ss == 34'd0);
				nx_w.sq_val = {1'b0, ss[31:0], 20'd0};
				nx_w.sq_res = '0;
				rnd = 34'(prev_w.pxprod) + 34'sd128;
				nx_w.px = rnd[31:8];
				nx_w.cx = CORDIC_X0;
				nx_w.cy = '0;
				nx_w.cz = $signed({4'd0, prev_w.phase[29:0]});
				nx_w.quad = prev_w.phase[31:30];
			end

			// One bit of the square root per stage.
			if (k >= ST_ITER0 && k <= SQRT_LAST) begin
				trial = prev_w.sq_res + (53'd1 << SB);
				if (prev_w.sq_val >= trial) begin
					nx_w.sq_val = prev_w.sq_val - trial;
					nx_w.sq_res = (prev_w.sq_res >> 1) + (53'd1 << SB);
				end else begin
					nx_w.sq_res = prev_w.sq_res >> 1;
				end
			end

			// One CORDIC rotation per stage.
			if (k >= ST_ITER0 && k <= CORDIC_LAST) begin
				sh_x = prev_w.cy >>> CI;
				sh_y = prev_w.cx >>> CI;
				if (!prev_w.cz[33]) begin
					nx_w.cx = prev_w.cx - sh_x;
					nx_w.cy = prev_w.cy + sh_y;
					nx_w.cz = prev_w.cz - atan_turn(4'(CI));
				end else begin
					nx_w.cx = prev_w.cx + sh_x;
					nx_w.cy = prev_w.cy - sh_y;
					nx_w.cz = prev_w.cz + atan_turn(4'(CI));
				end
			end

			if (k == ST_CSROUND) begin
				c_w = 34'(sat16((prev_w.cx + 34'sd16384) >>> 15));
				s_w = 34'(sat16((prev_w.cy + 34'sd16384) >>> 15));
				case (prev_w.quad)
					2'd0: begin
						nx_w.ny = c_w[15:0];
						nx_w.nz = s_w[15:0];
					end
					2'd1: begin
						nx_w.ny = sat16(-s_w);
						nx_w.nz = c_w[15:0];
					end
					2'd2: begin
						nx_w.ny = sat16(-c_w);
						nx_w.nz = sat16(-s_w);
					end
					default: begin
						nx_w.ny = s_w[15:0];
						nx_w.nz = sat16(-c_w);
					end
				endcase
			end

			if (k == ST_PMUL) begin
				nx_w.pyprod = $signed({1'b0, radius_q}) * prev_w.ny;
				nx_w.pzprod = $signed({1'b0, radius_q}) * prev_w.nz;
			end

			if (k == ST_PROUND) begin
				rnd = 34'(prev_w.pyprod) + 34'sd128;
				nx_w.py = rnd[31:8];
				rnd = 34'(prev_w.pzprod) + 34'sd128;
				nx_w.pz = rnd[31:8];
			end

			// Rounded dividend |v| * 2^25 + m/2 for each lane.
			if (k == ST_DIVINIT) begin
				nx_w.mval = prev_w.sq_res[25:0];
				for (int l = 0; l < 3; l++) begin
					rv = (l == 0) ? 17'(prev_w.rx) : ((l == 1) ? 17'(prev_w.ry) : 17'(prev_w.rz));
					nx_w.neg[l] = rv[16];
					mag = rv[16] ? 16'(-rv) : rv[15:0];
					nx_w.rem[l] = ({26'd0, mag} << 25) + {17'd0, prev_w.sq_res[25:1]};
					nx_w.dq[l] = '0;
				end
			end

			// One quotient bit per lane per stage, restoring division.
			if (k > ST_DIVINIT && k <= DIV_LAST) begin
				dvs = {17'd0, prev_w.mval} << DJ;
				for (int l = 0; l < 3; l++) begin
					if ({1'b0, prev_w.rem[l]} >= dvs) begin
						nx_w.rem[l] = 42'({1'b0, prev_w.rem[l]} - dvs);
						nx_w.dq[l][DJ] = 1'b1;
					end
				end
			end

			if (k == ST_DIR) begin
				for (int l = 0; l < 3; l++) begin
					q = prev_w.dq[l];
					if (prev_w.deg) nx_w.dir[l] = '0;
					else if (prev_w.neg[l]) nx_w.dir[l] = 16'(-q);
					else if (q[15]) nx_w.dir[l] = 16'h7fff;
					else nx_w.dir[l] = q;
				end
			end

			if (k == ST_DOT) begin
				nx_w.prod[0] = prev_w.px * $signed(prev_w.dir[0]);
				nx_w.prod[1] = prev_w.py * $signed(prev_w.dir[1]);
				nx_w.prod[2] = prev_w.pz * $signed(prev_w.dir[2]);
			end

			// Flip an inward direction; the most negative code flips to the maximum.
			if (k == NSTAGE) begin
				dot = 42'($signed(prev_w.prod[0])) + 42'($signed(prev_w.prod[1]))
					+ 42'($signed(prev_w.prod[2]));
				if (dot[41]) begin
					for (int l = 0; l < 3; l++) begin
						if (prev_w.dir[l] == 16'h8000) nx_w.dir[l] = 16'h7fff;
						else nx_w.dir[l] = 16'(-prev_w.dir[l]);
					end
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en_w[k]) begin
				v_s[k] <= vin_w;
			end
		end

		always_ff @(posedge clk) begin
			if (en_w[k]) begin
				pl_s[k] <= nx_w;
			end
		end
	end

	assign ray.valid = v_s[NSTAGE];
	assign ray.data.normal_y = pl_s[NSTAGE].ny;
	assign ray.data.normal_z = pl_s[NSTAGE].nz;
	assign ray.data.pos_x = pl_s[NSTAGE].px;
	assign ray.data.pos_y = pl_s[NSTAGE].py;
	assign ray.data.pos_z = pl_s[NSTAGE].pz;
	assign ray.data.dir_x = pl_s[NSTAGE].dir[0];
	assign ray.data.dir_y = pl_s[NSTAGE].dir[1];
	assign ray.data.dir_z = pl_s[NSTAGE].dir[2];
	assign ray.data.degenerate = pl_s[NSTAGE].deg;

endmodule

// ===== dv/tb_cylinder_ray_emitter_top.sv =====
// Self-checking testbench of the cylinder ray emitter: directed and random
// sample sets against an in-bench ray predictor, with APB register writes.
// Depends on cre_pkg, cre_in_if, cre_out_if and cylinder_ray_emitter_top.
`timescale 1ns / 1ps

module tb_cylinder_ray_emitter_top;
	import cre_pkg::*;

	localparam int LATENCY = NSTAGE;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int N_RANDOM = 455;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [2:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	cre_in_if sample_ch();
	cre_out_if ray_ch();

	cylinder_ray_emitter_top u_top (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.sample(sample_ch.sink), .ray(ray_ch.source)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Predictor copy of the two registers.
	logic [15:0] radius_q, length_q;

	sample_t pending_samples[$];
	ray_t expected_rays[$];

	int n_errors;
	int n_sent, n_rays, n_degenerate;
	bit send_idle_en, recv_idle_en, done;
	bit hold_rays;
	int send_gap, recv_gap;
	int quiet_cycles;

	// Arithmetic right shift that floors, on 64-bit signed values.
	function automatic longint fshr(input longint v, input int s);
		return v >>> s;
	endfunction

	function automatic longint clamp_q15(input longint v);
		if (v > 32767) return 32767;
		if (v < -32768) return -32768;
		return v;
	endfunction

	function automatic longint arctan_phase(input int i);
		longint tbl[16] = '{536870912, 316933406, 167458907, 85004756, 42667332,
			21354465, 10679838, 5340245, 2670167, 1335087, 667544, 333772,
			166886, 83443, 41722, 20861};
		return tbl[i];
	endfunction

	function automatic longint unsigned int_sqrt(input longint unsigned v);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function automatic longint unit_component(input longint v, input longint unsigned m);
		longint unsigned mag;
		longint q;
		mag = (v < 0) ? -v : v;
		q = longint'(((mag << 25) + (m >> 1)) / m);
		return clamp_q15(v < 0 ? -q : q);
	endfunction

	// Computes the ray expected for one sample set with the current registers.
	function automatic ray_t predict_ray(input sample_t s);
		ray_t r;
		bit [31:0] phase;
		bit [1:0] quad;
		longint x, y, z, dx, dy, c, sn, ny, nz, px, py, pz, rx, ry, rz;
		longint vx, vy, vz, dot;
		longint unsigned m;
		phase = 32'(s.angle_sample) * 32'(PHASE_PER_CODE);
		quad = phase[31:30];
		x = CORDIC_X0;
		y = 0;
		z = longint'(phase[29:0]);
		for (int i = 0; i < 16; i++) begin
			dx = fshr(y, i);
			dy = fshr(x, i);
			if (z >= 0) begin
				x -= dx; y += dy; z -= arctan_phase(i);
			end else begin
				x += dx; y -= dy; z += arctan_phase(i);
			end
		end
		c = clamp_q15(fshr(x + 16384, 15));
		sn = clamp_q15(fshr(y + 16384, 15));
		case (quad)
			2'd0: begin ny = c; nz = sn; end
			2'd1: begin ny = clamp_q15(-sn); nz = c; end
			2'd2: begin ny = clamp_q15(-c); nz = clamp_q15(-sn); end
			default: begin ny = sn; nz = clamp_q15(-c); end
		endcase
		px = fshr(longint'(length_q) * longint'(s.axial_sample) + 128, 8);
		py = fshr(longint'(radius_q) * ny + 128, 8);
		pz = fshr(longint'(radius_q) * nz + 128, 8);
		rx = s.raw_dir_x;
		ry = s.raw_dir_y;
		rz = s.raw_dir_z;
		vx = 0; vy = 0; vz = 0;
		r.degenerate = (rx == 0 && ry == 0 && rz == 0);
		if (!r.degenerate) begin
			m = int_sqrt(longint'(rx * rx + ry * ry + rz * rz) << 20);
			vx = unit_component(rx, m);
			vy = unit_component(ry, m);
			vz = unit_component(rz, m);
			dot = px * vx + py * vy + pz * vz;
			// Flip an inward ray so that it leaves the surface.
			if (dot < 0) begin
				vx = clamp_q15(-vx);
				vy = clamp_q15(-vy);
				vz = clamp_q15(-vz);
			end
		end
		r.normal_y = ny[15:0];
		r.normal_z = nz[15:0];
		r.pos_x = px[23:0];
		r.pos_y = py[23:0];
		r.pos_z = pz[23:0];
		r.dir_x = vx[15:0];
		r.dir_y = vy[15:0];
		r.dir_z = vz[15:0];
		return r;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		n_errors++;
		$display("ERROR ray %0d %s: got %0d expected %0d", n_rays, what, got, want);
	endtask

	function automatic sample_t make_sample(input int ax, input int ang,
		input int x, input int y, input int z);
		sample_t s;
		s.axial_sample = 16'(ax);
		s.angle_sample = 16'(ang);
		s.raw_dir_x = 16'(x);
		s.raw_dir_y = 16'(y);
		s.raw_dir_z = 16'(z);
		return s;
	endfunction

	function automatic sample_t random_sample();
		sample_t s;
		// Mostly nominal axial samples, sometimes any 16-bit value.
		if ($urandom_range(0, 9) == 0)
			s.axial_sample = 16'($urandom);
		else
			s.axial_sample = 16'($urandom_range(0, 32768) - 16384);
		s.angle_sample = 16'($urandom);
		s.raw_dir_x = 16'($urandom);
		s.raw_dir_y = 16'($urandom);
		s.raw_dir_z = 16'($urandom);
		if ($urandom_range(0, 40) == 0) begin
			s.raw_dir_x = '0; s.raw_dir_y = '0; s.raw_dir_z = '0;
		end
		return s;
	endfunction

	// Sample driver: pops pending sample sets, inserts idle bursts.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_ch.valid <= 1'b0;
			sample_ch.data <= '0;
			send_gap <= 0;
		end else begin
			if (sample_ch.valid && sample_ch.ready) begin
				expected_rays.push_back(predict_ray(sample_ch.data));
				n_sent++;
			end
			if (!sample_ch.valid || sample_ch.ready) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
					sample_ch.valid <= 1'b0;
				end else if (pending_samples.size() > 0) begin
					if (send_idle_en && $urandom_range(0, 9) == 0) begin
						send_gap <= $urandom_range(1, 16) - 1;
						sample_ch.valid <= 1'b0;
					end else begin
						sample_ch.data <= pending_samples.pop_front();
						sample_ch.valid <= 1'b1;
					end
				end else begin
					sample_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Ray receiver: random stall bursts, plus a long hold when requested.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ray_ch.ready <= 1'b0;
			recv_gap <= 0;
		end else if (hold_rays) begin
			ray_ch.ready <= 1'b0;
		end else if (recv_gap > 0) begin
			recv_gap <= recv_gap - 1;
			ray_ch.ready <= 1'b0;
		end else if (recv_idle_en && $urandom_range(0, 9) == 0) begin
			recv_gap <= $urandom_range(1, 16) - 1;
			ray_ch.ready <= 1'b0;
		end else begin
			ray_ch.ready <= 1'b1;
		end
	end

	// Ray monitor: every accepted ray is checked field by field.
	always @(posedge clk) begin
		if (arst_n && ray_ch.valid && ray_ch.ready) begin
			ray_t got, want;
			got = ray_ch.data;
			if (expected_rays.size() == 0) begin
				report_mismatch("unexpected ray", 0, 0);
			end else begin
				want = expected_rays.pop_front();
				if (got.normal_y !== want.normal_y)
					report_mismatch("normal_y", got.normal_y, want.normal_y);
				if (got.normal_z !== want.normal_z)
					report_mismatch("normal_z", got.normal_z, want.normal_z);
				if (got.pos_x !== want.pos_x) report_mismatch("pos_x", got.pos_x, want.pos_x);
				if (got.pos_y !== want.pos_y) report_mismatch("pos_y", got.pos_y, want.pos_y);
				if (got.pos_z !== want.pos_z) report_mismatch("pos_z", got.pos_z, want.pos_z);
				if (got.dir_x !== want.dir_x) report_mismatch("dir_x", got.dir_x, want.dir_x);
				if (got.dir_y !== want.dir_y) report_mismatch("dir_y", got.dir_y, want.dir_y);
				if (got.dir_z !== want.dir_z) report_mismatch("dir_z", got.dir_z, want.dir_z);
				if (got.degenerate !== want.degenerate)
					report_mismatch("degenerate", got.degenerate, want.degenerate);
				if (want.degenerate) n_degenerate++;
			end
			n_rays++;
		end
	end

	// Watchdog: counts cycles without any accepted transaction. The long
	// receiver hold is far shorter than the limit.
	always @(posedge clk) begin
		if ((sample_ch.valid && sample_ch.ready) || (ray_ch.valid && ray_ch.ready) || done)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog expired with %0d rays outstanding", expected_rays.size());
			$display("tb: failure");
			$finish;
		end
	end

	// APB write: setup cycle then access cycle; pready is always high.
	task automatic apb_write(input logic [2:0] addr, input logic [15:0] value);
		@(posedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= addr; pwdata <= {16'h0, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		if (addr == REG_RADIUS) radius_q = value;
		else if (addr == REG_LENGTH) length_q = value;
	endtask

	// Waits until every sample set is sent and every ray has come back, then
	// lets the pipeline drain before registers may change. The queues and
	// the valid flag are looked at on the falling edge, once they have settled.
	task automatic wait_idle();
		while (pending_samples.size() > 0 || sample_ch.valid || expected_rays.size() > 0)
			@(negedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic load_directed();
		int angles[8] = '{0, 16384, 16400, 32768, 49152, 65535, 10923, 8192};
		pending_samples.push_back(make_sample(0, 0, 0, 0, 0));
		pending_samples.push_back(make_sample(-16384, 0, 32767, 0, 0));
		pending_samples.push_back(make_sample(16384, 0, -32768, 0, 0));
		pending_samples.push_back(make_sample(-32768, 0, -32768, -32768, -32768));
		pending_samples.push_back(make_sample(32767, 65535, 32767, 32767, 32767));
		pending_samples.push_back(make_sample(0, 16384, 0, -32768, 0));
		pending_samples.push_back(make_sample(0, 32768, 0, 32767, 1));
		pending_samples.push_back(make_sample(0, 49152, 0, 0, -32768));
		pending_samples.push_back(make_sample(0, 0, 0, 1, 0));
		pending_samples.push_back(make_sample(0, 0, 0, -1, 0));
		pending_samples.push_back(make_sample(5, 12000, 0, 0, 0));
		foreach (angles[i])
			pending_samples.push_back(make_sample(1000 * i - 4000, angles[i], -1, 1, -1));
	endtask

	task automatic load_random(input int n);
		repeat (n) pending_samples.push_back(random_sample());
	endtask

	initial begin
		logic [15:0] settings[5][2] = '{
			'{16'd256, 16'd256}, '{16'hffff, 16'hffff}, '{16'd0, 16'd0},
			'{16'd1, 16'hffff}, '{16'h0000, 16'd0}};
		arst_n = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		radius_q = RADIUS_RST;
		length_q = LENGTH_RST;
		n_errors = 0; n_sent = 0; n_rays = 0; n_degenerate = 0;
		send_idle_en = 1'b0; recv_idle_en = 1'b0; done = 1'b0; hold_rays = 1'b0;
		quiet_cycles = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Directed sample sets under the reset register values.
		load_directed();
		wait_idle();

		// Register sweep: each setting but the first gets directed and random traffic.
		send_idle_en = 1'b1; recv_idle_en = 1'b1;
		for (int k = 1; k < 5; k++) begin
			settings[4][0] = 16'($urandom);
			settings[4][1] = 16'($urandom);
			apb_write(REG_RADIUS, settings[k][0]);
			apb_write(REG_LENGTH, settings[k][1]);
			load_directed();
			load_random(60);
			// In the first phase the receiver holds off for a long stretch
			// while samples keep coming, so the pipeline fills and stalls.
			if (k == 1) begin
				hold_rays = 1'b1;
				repeat (200) @(posedge clk);
				hold_rays = 1'b0;
			end
			wait_idle();
		end

		// Back to nominal sizes; the sender pauses until all rays are back,
		// then the last stretch runs with no idling on either side.
		apb_write(REG_RADIUS, 16'd640);
		apb_write(REG_LENGTH, 16'd1536);
		load_random(N_RANDOM - 240 - 120);
		wait_idle();
		send_idle_en = 1'b0; recv_idle_en = 1'b0;
		load_random(120);
		wait_idle();
		done = 1'b1;

		$display("sent %0d sample sets, checked %0d rays (%0d degenerate)",
			n_sent, n_rays, n_degenerate);
		$display("covered five register settings including both extremes");
		if (n_errors == 0 && expected_rays.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
